// ===== rtl/core/rtec_pkg.sv =====
// shared types, codes and entropy table functions of the read top-two entropy classifier
package rtec_pkg;

  localparam int PROB_W    = 16;
  localparam int READ_W    = 32;
  localparam int BUCKET_W  = 32;
  localparam int ENTROPY_W = 20;
  localparam int CLASS_W   = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  // widest table entry is near p = 1/e, about 2174 in 1/4096 bit
  localparam int ENT_W     = 12;
  localparam int FRAC_BITS = 30;

  localparam logic [ENTROPY_W-1:0] ENTROPY_MAX = {ENTROPY_W{1'b1}};

  // request commands
  localparam logic [CMD_W-1:0] CMD_CAND      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EMPTY     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COLLAPSED = 2'd2;

  // dropout classes
  localparam logic [CLASS_W-1:0] CLS_ACTIVE    = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_CONVERGED = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_AMBIGUOUS = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_LOW_CONF  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_ORPHANED  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIG_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CONF_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_COLLAPSE = 2'd3;

  // register reset values
  localparam logic [PROB_W-1:0] RST_COLLAPSE_THR = 16'd58982;
  localparam logic [PROB_W-1:0] RST_AMBIG_GAP    = 16'd6554;
  localparam logic [PROB_W-1:0] RST_LOW_CONF_THR = 16'd19661;
  localparam logic              RST_AUTO_COLLAPSE = 1'b1;

  typedef logic [ENT_W-1:0] ent_t;

  // log2(m) with 30 fraction bits, fraction by repeated squaring; elaboration only
  function automatic logic [63:0] fixed_log2(input logic [63:0] m);
    logic [63:0] k;
    logic [63:0] x;
    logic [63:0] frac;
    k    = 64'd0;
    frac = 64'd0;
    for (int i = 0; i < 63; i++) begin
      if ((m >> (i + 1)) != 64'd0) k = 64'(i + 1);
    end
    x = (m << FRAC_BITS) >> k;
    for (int i = 0; i < FRAC_BITS; i++) begin
      x    = (x * x) >> FRAC_BITS;
      frac = frac << 1;
      if (x >= (64'd2 << FRAC_BITS)) begin
        frac = frac | 64'd1;
        x    = x >> 1;
      end
    end
    return (k << FRAC_BITS) | frac;
  endfunction

  // -p*log2(p) at the bin midpoint, in 1/4096 bit
  function automatic ent_t entropy_entry(input int unsigned idx, input int bits);
    logic [63:0] m;
    logic [63:0] full;
    logic [63:0] v;
    m    = 64'(2 * idx + 1);
    full = 64'(bits + 1) << FRAC_BITS;
    v    = m * (full - fixed_log2(m)) * 64'd4096;
    v    = v + (64'd1 << (bits + FRAC_BITS));
    v    = v >> (bits + FRAC_BITS + 1);
    return v[ENT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/rtec_if.sv =====
// valid/ready channel interfaces: candidate stream, classification result, register writes
interface rtec_cand_if;
  logic                             valid;
  logic                             ready;
  logic [rtec_pkg::CMD_W-1:0]       command;
  logic [rtec_pkg::READ_W-1:0]      read_index;
  logic [rtec_pkg::PROB_W-1:0]      probability;
  logic [rtec_pkg::BUCKET_W-1:0]    bucket;
  logic                             last;
  modport source (output valid, command, read_index, probability, bucket, last, input ready);
  modport sink (input valid, command, read_index, probability, bucket, last, output ready);
endinterface

interface rtec_result_if;
  logic                             valid;
  logic                             ready;
  logic [rtec_pkg::READ_W-1:0]      read_id;
  logic [rtec_pkg::PROB_W-1:0]      top_probability;
  logic [rtec_pkg::PROB_W-1:0]      runner_probability;
  logic [rtec_pkg::BUCKET_W-1:0]    top_bin;
  logic [rtec_pkg::BUCKET_W-1:0]    runner_bin;
  logic [rtec_pkg::ENTROPY_W-1:0]   entropy;
  logic [rtec_pkg::CLASS_W-1:0]     dropout_class;
  logic                             collapse_now;
  modport source (output valid, read_id, top_probability, runner_probability, top_bin,
                  runner_bin, entropy, dropout_class, collapse_now, input ready);
  modport sink (input valid, read_id, top_probability, runner_probability, top_bin,
                runner_bin, entropy, dropout_class, collapse_now, output ready);
endinterface

interface rtec_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rtec_pkg::CFG_IDX_W-1:0]   index;
  logic [rtec_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/read_top2_entropy_classifier_top.sv =====
// top level of the read top-two entropy classifier
// Takes one candidate request per clock and keeps the two largest Q0.16 probabilities
// of the open read with their buckets, plus a saturating entropy sum from a constant
// -p*log2(p) ROM with 2^ENTROPY_TABLE_BITS entries. When the request that ends the read
// (last candidate or empty read) is accepted, the ROM is read into the input stage
// register; that stage then folds the candidate into the running state and classifies
// into the result register. Throughput is one request per clock; candidates keep flowing
// while a result waits, and only a request that ends a read stalls behind an untaken
// result. Register writes are always taken at once.
module read_top2_entropy_classifier_top #(
  parameter int MAX_CANDIDATES     = 256,
  parameter int ENTROPY_TABLE_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  rtec_cand_if.sink     cand,
  rtec_result_if.source result,
  rtec_cfg_if.sink      cfg
);

  localparam int TBL_DEPTH = 2 ** ENTROPY_TABLE_BITS;
  localparam int CNT_W     = $clog2(MAX_CANDIDATES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);

  // configuration registers
  logic [rtec_pkg::PROB_W-1:0] collapse_threshold;
  logic [rtec_pkg::PROB_W-1:0] ambiguity_gap;
  logic [rtec_pkg::PROB_W-1:0] low_confidence_threshold;
  logic                        collapse_enable;

  // input stage
  logic                           a_valid;
  logic [rtec_pkg::CMD_W-1:0]     a_cmd;
  logic [rtec_pkg::READ_W-1:0]    a_read;
  logic [rtec_pkg::PROB_W-1:0]    a_prob;
  logic [rtec_pkg::BUCKET_W-1:0]  a_bucket;
  logic                           a_last;
  rtec_pkg::ent_t                 a_ent;

  // running read state
  logic [rtec_pkg::PROB_W-1:0]    best_prob;
  logic [rtec_pkg::PROB_W-1:0]    runner_up_prob;
  logic [rtec_pkg::BUCKET_W-1:0]  best_bucket;
  logic [rtec_pkg::BUCKET_W-1:0]  runner_up_bucket;
  logic [rtec_pkg::ENTROPY_W-1:0] entropy_sum;
  logic [CNT_W-1:0]               cand_count;

  logic [rtec_pkg::PROB_W-1:0]    best_prob_next;
  logic [rtec_pkg::PROB_W-1:0]    runner_up_prob_next;
  logic [rtec_pkg::BUCKET_W-1:0]  best_bucket_next;
  logic [rtec_pkg::BUCKET_W-1:0]  runner_up_bucket_next;
  logic [rtec_pkg::ENTROPY_W-1:0] entropy_sum_next;
  logic [CNT_W-1:0]               cand_count_next;
  logic [rtec_pkg::ENTROPY_W:0]   entropy_wide;
  logic [rtec_pkg::PROB_W-1:0]    top_gap;
  logic [rtec_pkg::CLASS_W-1:0]   cls;

  logic out_free;
  logic a_emits;
  logic a_fire;

  // entropy ROM, built at elaboration
  rtec_pkg::ent_t ent_rom [TBL_DEPTH];

  for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_rom
    localparam rtec_pkg::ent_t ENTRY =
      rtec_pkg::entropy_entry(unsigned'(g), ENTROPY_TABLE_BITS);
    assign ent_rom[g] = ENTRY;
  end

  // handshake
  assign out_free   = !result.valid || result.ready;
  assign a_emits    = (a_cmd == rtec_pkg::CMD_CAND && a_last) || a_cmd == rtec_pkg::CMD_EMPTY;
  assign a_fire     = a_valid && (!a_emits || out_free);
  assign cand.ready = !a_valid || a_fire;
  assign cfg.ready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      collapse_threshold       <= rtec_pkg::RST_COLLAPSE_THR;
      ambiguity_gap            <= rtec_pkg::RST_AMBIG_GAP;
      low_confidence_threshold <= rtec_pkg::RST_LOW_CONF_THR;
      collapse_enable          <= rtec_pkg::RST_AUTO_COLLAPSE;
    end else if (cfg.valid) begin
      case (cfg.index)
        rtec_pkg::REG_COLLAPSE_THR:  collapse_threshold       <= cfg.data;
        rtec_pkg::REG_AMBIG_GAP:     ambiguity_gap            <= cfg.data;
        rtec_pkg::REG_LOW_CONF_THR:  low_confidence_threshold <= cfg.data;
        rtec_pkg::REG_AUTO_COLLAPSE: collapse_enable          <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // input stage with ROM read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cand.ready) begin
      a_valid <= cand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cand.ready && cand.valid) begin
      a_cmd    <= cand.command;
      a_read   <= cand.read_index;
      a_prob   <= cand.probability;
      a_bucket <= cand.bucket;
      a_last   <= cand.last;
      a_ent    <= ent_rom[cand.probability[rtec_pkg::PROB_W-1 -: ENTROPY_TABLE_BITS]];
    end
  end

  // fold candidate into top two and entropy
  always_comb begin
    best_prob_next        = best_prob;
    runner_up_prob_next   = runner_up_prob;
    best_bucket_next      = best_bucket;
    runner_up_bucket_next = runner_up_bucket;
    entropy_sum_next      = entropy_sum;
    cand_count_next       = cand_count;
    entropy_wide          = {1'b0, entropy_sum} + (rtec_pkg::ENTROPY_W + 1)'(a_ent);
    if (a_cmd == rtec_pkg::CMD_CAND && cand_count < CNT_MAX) begin
      cand_count_next = cand_count + CNT_W'(1);
      if (a_prob > best_prob) begin
        runner_up_prob_next   = best_prob;
        runner_up_bucket_next = best_bucket;
        best_prob_next        = a_prob;
        best_bucket_next      = a_bucket;
      end else if (a_prob > runner_up_prob) begin
        runner_up_prob_next   = a_prob;
        runner_up_bucket_next = a_bucket;
      end
      if (a_prob != '0) begin
        if (entropy_wide[rtec_pkg::ENTROPY_W]) begin
          entropy_sum_next = rtec_pkg::ENTROPY_MAX;
        end else begin
          entropy_sum_next = entropy_wide[rtec_pkg::ENTROPY_W-1:0];
        end
      end
    end
  end

  // classify the closing read
  assign top_gap = best_prob_next - runner_up_prob_next;

  always_comb begin
    if (best_prob_next == '0) begin
      cls = rtec_pkg::CLS_ORPHANED;
    end else if (best_prob_next >= collapse_threshold) begin
      cls = rtec_pkg::CLS_CONVERGED;
    end else if (top_gap < ambiguity_gap && runner_up_prob_next != '0) begin
      cls = rtec_pkg::CLS_AMBIGUOUS;
    end else if (best_prob_next < low_confidence_threshold) begin
      cls = rtec_pkg::CLS_LOW_CONF;
    end else begin
      cls = rtec_pkg::CLS_ACTIVE;
    end
  end

  // read state update; any non-candidate command or a last mark starts a fresh read
  always_ff @(posedge clk) begin
    if (rst) begin
      best_prob        <= '0;
      runner_up_prob   <= '0;
      best_bucket      <= '0;
      runner_up_bucket <= '0;
      entropy_sum      <= '0;
      cand_count       <= '0;
    end else if (a_fire) begin
      if (a_cmd != rtec_pkg::CMD_CAND || a_last) begin
        best_prob        <= '0;
        runner_up_prob   <= '0;
        best_bucket      <= '0;
        runner_up_bucket <= '0;
        entropy_sum      <= '0;
        cand_count       <= '0;
      end else begin
        best_prob        <= best_prob_next;
        runner_up_prob   <= runner_up_prob_next;
        best_bucket      <= best_bucket_next;
        runner_up_bucket <= runner_up_bucket_next;
        entropy_sum      <= entropy_sum_next;
        cand_count       <= cand_count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (a_fire && a_emits) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_emits) begin
      result.read_id <= a_read;
      if (a_cmd == rtec_pkg::CMD_EMPTY) begin
        result.top_probability    <= '0;
        result.runner_probability <= '0;
        result.top_bin            <= '0;
        result.runner_bin         <= '0;
        result.entropy            <= '0;
        result.dropout_class      <= rtec_pkg::CLS_ORPHANED;
        result.collapse_now       <= 1'b0;
      end else begin
        result.top_probability    <= best_prob_next;
        result.runner_probability <= runner_up_prob_next;
        result.top_bin            <= best_bucket_next;
        result.runner_bin         <= runner_up_bucket_next;
        result.entropy            <= entropy_sum_next;
        result.dropout_class      <= cls;
        result.collapse_now       <= (cls == rtec_pkg::CLS_CONVERGED) && collapse_enable;
      end
    end
  end

  // checks
  a_order: assert property (@(posedge clk) disable iff (rst)
    runner_up_prob <= best_prob)
    else $error("runner-up probability above top");

  a_count: assert property (@(posedge clk) disable iff (rst)
    cand_count <= CNT_MAX)
    else $error("candidate count beyond limit");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    a_fire && a_emits |=> best_prob == '0 && entropy_sum == '0 && cand_count == '0)
    else $error("read state not cleared after result");

  a_entropy: assert property (@(posedge clk) disable iff (rst)
    entropy_sum != '0 |-> best_prob != '0)
    else $error("entropy gathered without a positive candidate");

  a_collapse: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.collapse_now |-> result.dropout_class == rtec_pkg::CLS_CONVERGED)
    else $error("collapse flagged on a read that is not converged");

endmodule
